// ----- design/tie_averaged_confusion_counts_top_macros.svh -----
// Assertion macros shared by the top level of the tie-averaged confusion counter.
`ifndef TIE_AVERAGED_CONFUSION_COUNTS_TOP_MACROS_SVH
`define TIE_AVERAGED_CONFUSION_COUNTS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TACC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tacc_pkg.sv -----
// Shared constants and controller/datapath signal groups of the tie-averaged confusion counter.
package tacc_pkg;

  localparam int SCORE_W   = 32;
  localparam int CNT_OUT_W = 40;
  localparam int RUN_W     = 6;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_RUN_DEF    = 63;

  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic init_row;
    logic count;
    logic div_start;
    logic rows_init;
    logic row_push;
    logic run_end;
    logic clear;
    logic by_len;
    logic eod_phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic seen_first;
    logic score_diff;
    logic len_full;
    logic len_gt1;
    logic row_last;
    logic out_free;
    logic item_eod;
    logic div_busy;
  } ctrl_status_t;

endpackage

// ----- design/tacc_if.sv -----
// Input item and result row channel interfaces.
interface tacc_item_if import tacc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      label_positive;
  logic signed [SCORE_W-1:0] score;
  logic                      end_of_data;

  modport source (output valid, label_positive, score, end_of_data, input ready);
  modport sink   (input valid, label_positive, score, end_of_data, output ready);
endinterface

interface tacc_row_if import tacc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CNT_OUT_W-1:0]      tp_count;
  logic [CNT_OUT_W-1:0]      fp_count;
  logic signed [SCORE_W-1:0] row_score;
  logic                      is_interpolated;
  logic                      run_split;
  logic                      final_row;
  logic                      last;

  modport source (output valid, tp_count, fp_count, row_score, is_interpolated, run_split,
                  final_row, last, input ready);
  modport sink   (input valid, tp_count, fp_count, row_score, is_interpolated, run_split,
                  final_row, last, output ready);
endinterface

// ----- design/tacc_ctrl.sv -----
// Sequencing state machine of the tie-averaged confusion counter.
module tacc_ctrl import tacc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_INIT   = 7'b0000100,
    S_COUNT  = 7'b0001000,
    S_CLOSE  = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_ROWS   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   eod_phase_q, eod_phase_d;
  logic   by_len_q, by_len_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.by_len    = by_len_q;
    cmd_o.eod_phase = eod_phase_q;
    state_d         = state_q;
    eod_phase_d     = eod_phase_q;
    by_len_d        = by_len_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!status_i.seen_first) begin
          state_d = S_INIT;
        end else if (status_i.score_diff) begin
          by_len_d    = 1'b0;
          eod_phase_d = 1'b0;
          state_d     = S_CLOSE;
        end else if (status_i.len_full) begin
          by_len_d    = 1'b1;
          eod_phase_d = 1'b0;
          state_d     = S_CLOSE;
        end else begin
          state_d = S_COUNT;
        end
      end
      S_INIT: begin
        if (status_i.out_free) begin
          cmd_o.init_row = 1'b1;
          state_d        = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.count = 1'b1;
        if (status_i.item_eod) begin
          eod_phase_d = 1'b1;
          by_len_d    = 1'b0;
          state_d     = S_CLOSE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CLOSE: begin
        // a single-item run needs only its exact row
        if (status_i.len_gt1) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.rows_init = 1'b1;
          state_d         = S_ROWS;
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.rows_init = 1'b1;
          state_d         = S_ROWS;
        end
      end
      S_ROWS: begin
        if (status_i.out_free) begin
          cmd_o.row_push = 1'b1;
          if (status_i.row_last) begin
            if (eod_phase_q) begin
              cmd_o.clear = 1'b1;
              state_d     = S_IDLE;
            end else begin
              cmd_o.run_end = 1'b1;
              state_d       = S_COUNT;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eod_phase_q <= 1'b0;
      by_len_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      eod_phase_q <= eod_phase_d;
      by_len_q    <= by_len_d;
    end
  end

endmodule

// ----- design/tacc_div.sv -----
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
module tacc_div import tacc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [RUN_W-1:0]                     divisor_i,
  input  logic [1:0][RUN_W+FRAC_BITS-1:0]      dividend_i,
  output logic                                 busy_o,
  output logic [1:0][RUN_W+FRAC_BITS-1:0]      quo_o,
  output logic [1:0][RUN_W-1:0]                rem_o
);

  localparam int DVD_W = RUN_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                   busy_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [RUN_W-1:0]       div_q;
  logic [1:0][DVD_W-1:0]  quo_q, quo_d;
  logic [1:0][RUN_W-1:0]  rem_q, rem_d;

  always_comb begin
    logic [RUN_W:0] trial;
    logic           ge;
    for (int l = 0; l < 2; l++) begin
      trial    = {rem_q[l], quo_q[l][DVD_W-1]};
      ge       = (trial >= {1'b0, div_q});
      rem_d[l] = ge ? RUN_W'(trial - {1'b0, div_q}) : trial[RUN_W-1:0];
      quo_d[l] = {quo_q[l][DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/tacc_dp.sv -----
// Datapath: running counts, run tracking, row interpolation and output register.
module tacc_dp import tacc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output ctrl_status_t              status_o,
  input  logic                      label_positive_i,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic                      end_of_data_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [CNT_OUT_W-1:0]      tp_count_o,
  output logic [CNT_OUT_W-1:0]      fp_count_o,
  output logic signed [SCORE_W-1:0] row_score_o,
  output logic                      is_interpolated_o,
  output logic                      run_split_o,
  output logic                      final_row_o,
  output logic                      last_o
);

  localparam int DVD_W = RUN_W + FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // lane 0 counts positives, lane 1 negatives
  logic [1:0][COUNT_BITS-1:0] total_q, start_q, diff;
  logic [RUN_W-1:0]           run_len_q;
  logic signed [SCORE_W-1:0]  run_score_q;
  logic                       seen_first_q;
  logic                       split_pending_q;

  logic                       label_q;
  logic signed [SCORE_W-1:0]  score_q;
  logic                       eod_q;

  logic [RUN_W-1:0]           k_q;
  logic [1:0][DVD_W-1:0]      qacc_q, q_base, q_next;
  logic [1:0][RUN_W-1:0]      racc_q, r_base, r_next;

  logic [1:0][DVD_W-1:0]      dvd, quo;
  logic [1:0][RUN_W-1:0]      rem;
  logic                       div_busy;

  logic                       row_last;
  logic [1:0][CNT_OUT_W-1:0]  row_cnt;
  logic signed [SCORE_W-1:0]  init_score;
  logic                       out_valid_q;
  logic                       out_free;

  function automatic logic [CNT_OUT_W-1:0] fx_shift(logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v) << FRAC_BITS;
    return w[CNT_OUT_W-1:0];
  endfunction

  // run increase is bounded by the run length, so it fits the run width
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l] = total_q[l] - start_q[l];
      dvd[l]  = DVD_W'(diff[l][RUN_W-1:0]) << FRAC_BITS;
    end
  end

  tacc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  (run_len_q),
    .dividend_i (dvd),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // advance quotient and remainder of k*delta/len by one row; seed with len/2 for rounding
  always_comb begin
    logic [RUN_W:0] r_sum;
    logic           carry;
    for (int l = 0; l < 2; l++) begin
      q_base[l] = cmd_i.rows_init ? '0 : qacc_q[l];
      r_base[l] = cmd_i.rows_init ? (run_len_q >> 1) : racc_q[l];
      r_sum     = {1'b0, r_base[l]} + {1'b0, rem[l]};
      carry     = (r_sum >= {1'b0, run_len_q});
      r_next[l] = carry ? RUN_W'(r_sum - {1'b0, run_len_q}) : r_sum[RUN_W-1:0];
      q_next[l] = q_base[l] + quo[l] + DVD_W'(carry);
    end
  end

  assign row_last = (k_q == run_len_q);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      row_cnt[l] = row_last ? fx_shift(total_q[l])
                            : fx_shift(start_q[l]) + CNT_OUT_W'(qacc_q[l]);
    end
  end

  assign init_score = (score_q == SCORE_MIN) ? score_q : score_q - SCORE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q         <= '0;
      start_q         <= '0;
      run_len_q       <= '0;
      run_score_q     <= '0;
      seen_first_q    <= 1'b0;
      split_pending_q <= 1'b0;
    end else if (cmd_i.clear) begin
      total_q         <= '0;
      start_q         <= '0;
      run_len_q       <= '0;
      run_score_q     <= '0;
      seen_first_q    <= 1'b0;
      split_pending_q <= 1'b0;
    end else if (cmd_i.init_row) begin
      seen_first_q    <= 1'b1;
      split_pending_q <= 1'b0;
      start_q         <= total_q;
      run_len_q       <= '0;
      run_score_q     <= score_q;
    end else if (cmd_i.run_end) begin
      split_pending_q <= cmd_i.by_len;
      start_q         <= total_q;
      run_len_q       <= '0;
      run_score_q     <= score_q;
    end else if (cmd_i.count) begin
      // saturate the running counts
      if (label_q) begin
        if (total_q[0] != COUNT_MAX) total_q[0] <= total_q[0] + COUNT_BITS'(1);
      end else begin
        if (total_q[1] != COUNT_MAX) total_q[1] <= total_q[1] + COUNT_BITS'(1);
      end
      run_len_q <= run_len_q + RUN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      label_q <= label_positive_i;
      score_q <= score_i;
      eod_q   <= end_of_data_i;
    end
    if (cmd_i.rows_init || cmd_i.row_push) begin
      qacc_q <= q_next;
      racc_q <= r_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.rows_init) begin
      k_q <= RUN_W'(1);
    end else if (cmd_i.row_push) begin
      k_q <= k_q + RUN_W'(1);
    end
  end

  // output register: one word held until taken
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.init_row || cmd_i.row_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_row) begin
      tp_count_o        <= '0;
      fp_count_o        <= '0;
      row_score_o       <= init_score;
      is_interpolated_o <= 1'b0;
      run_split_o       <= 1'b0;
      final_row_o       <= 1'b0;
      last_o            <= !eod_q;
    end else if (cmd_i.row_push) begin
      tp_count_o        <= row_cnt[0];
      fp_count_o        <= row_cnt[1];
      row_score_o       <= run_score_q;
      is_interpolated_o <= !row_last;
      run_split_o       <= split_pending_q | cmd_i.by_len;
      final_row_o       <= cmd_i.eod_phase & row_last;
      last_o            <= row_last & (cmd_i.eod_phase | !eod_q);
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.seen_first = seen_first_q;
  assign status_o.score_diff = (score_q != run_score_q);
  assign status_o.len_full   = (run_len_q >= RUN_W'(MAX_RUN));
  assign status_o.len_gt1    = (run_len_q > RUN_W'(1));
  assign status_o.row_last   = row_last;
  assign status_o.out_free   = out_free;
  assign status_o.item_eod   = eod_q;
  assign status_o.div_busy   = div_busy;

endmodule

// ----- design/tie_averaged_confusion_counts_top.sv -----
// Top level of the tie-averaged cumulative confusion counter.
//
//   channel  dir  word                                         accepted when
//   item_i   in   label_positive, score, end_of_data           valid && ready
//   row_o    out  tp/fp_count, row_score, flags, last           valid && ready
//
// An item that closes no run passes the accept, decide and count states. Closing a run
// of L items adds the close state and L row pushes, after a pass of the bit-serial
// divider when L > 1. The initial row adds the init state; the end-of-data run closes as any.
// Reset clears all counts and run state at once. Rows leave through a single
// output register; a stalled row_o holds the sequencer until the word is taken.
`include "tie_averaged_confusion_counts_top_macros.svh"

module tie_averaged_confusion_counts_top import tacc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tacc_item_if.sink    item_i,
  tacc_row_if.source   row_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         in_ready;

  tacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tacc_dp #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_RUN    (MAX_RUN)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .label_positive_i  (item_i.label_positive),
    .score_i           (item_i.score),
    .end_of_data_i     (item_i.end_of_data),
    .out_ready_i       (row_o.ready),
    .out_valid_o       (row_o.valid),
    .tp_count_o        (row_o.tp_count),
    .fp_count_o        (row_o.fp_count),
    .row_score_o       (row_o.row_score),
    .is_interpolated_o (row_o.is_interpolated),
    .run_split_o       (row_o.run_split),
    .final_row_o       (row_o.final_row),
    .last_o            (row_o.last)
  );

  assign item_i.ready = in_ready;

  `TACC_ASSERT(a_ready_not_dividing, item_i.ready, !status.div_busy, "item taken while dividing")
  `TACC_ASSERT(a_final_is_last, row_o.valid && row_o.final_row, row_o.last, "final row without last")
  `TACC_ASSERT_NEXT(a_accept_drops_ready, item_i.valid && item_i.ready, !item_i.ready, "ready held after accept")
  `TACC_ASSERT(a_push_into_free, cmd.row_push || cmd.init_row, status.out_free, "row pushed into full register")

endmodule

// ----- sim/tie_averaged_confusion_counts_top_test.sv -----
// Self-checking bench for the tie-averaged confusion counter: ranked items in, checked rows out.
import tacc_pkg::*;

typedef struct packed {
  logic [CNT_OUT_W-1:0] tp_count;
  logic [CNT_OUT_W-1:0] fp_count;
  logic [SCORE_W-1:0]   row_score;
  logic                 is_interpolated;
  logic                 run_split;
  logic                 final_row;
  logic                 last;
} conf_row_t;

// Running counts and tie runs of one data set, and the rows still owed by the block.
class row_ledger;
  bit [63:0]        pos_total;
  bit [63:0]        neg_total;
  bit [63:0]        run_pos0;
  bit [63:0]        run_neg0;
  int unsigned      run_len;
  bit [SCORE_W-1:0] run_score;
  bit               started;
  bit               split_open;
  conf_row_t        due_rows[$];
  int               error_count;

  function new();
    clear();
    error_count = 0;
  endfunction

  function void clear();
    pos_total  = 0;
    neg_total  = 0;
    run_pos0   = 0;
    run_neg0   = 0;
    run_len    = 0;
    run_score  = '0;
    started    = 1'b0;
    split_open = 1'b0;
  endfunction

  function void open_run(bit [SCORE_W-1:0] sc);
    run_pos0  = pos_total;
    run_neg0  = neg_total;
    run_len   = 0;
    run_score = sc;
  endfunction

  // Count k/len of the way from s to e, rounded half up; the run's own last row is exact.
  function bit [CNT_OUT_W-1:0] blend(bit [63:0] s, bit [63:0] e, int unsigned k,
                                     int unsigned len);
    bit [63:0] rise;
    bit [63:0] sum;
    if (k >= len || len == 0) begin
      sum = e << FRAC_BITS_DEF;
    end else begin
      rise = (e >= s) ? e - s : 64'd0;
      sum  = (s << FRAC_BITS_DEF) +
             (64'(k) * (rise << FRAC_BITS_DEF) + 64'(len / 2)) / 64'(len);
    end
    return sum[CNT_OUT_W-1:0];
  endfunction

  function void flush_run(bit split, bit fin);
    conf_row_t r;
    for (int unsigned k = 1; k <= run_len; k++) begin
      r                 = '0;
      r.tp_count        = blend(run_pos0, pos_total, k, run_len);
      r.fp_count        = blend(run_neg0, neg_total, k, run_len);
      r.row_score       = run_score;
      r.is_interpolated = (k < run_len);
      r.run_split       = split;
      r.final_row       = fin && (k == run_len);
      due_rows.push_back(r);
    end
  endfunction

  function void note_item(bit positive, bit [SCORE_W-1:0] sc, bit eod);
    int unsigned before_n;
    conf_row_t   r;
    bit [63:0]   count_max;
    count_max = (64'd1 << COUNT_BITS_DEF) - 1;
    before_n  = due_rows.size();
    if (!started) begin
      // zero row just below the first score, held at the minimum
      r           = '0;
      r.row_score = (sc == SCORE_MIN) ? sc : sc - 1;
      due_rows.push_back(r);
      started    = 1'b1;
      split_open = 1'b0;
      open_run(sc);
    end else if (sc != run_score) begin
      flush_run(split_open, 1'b0);
      split_open = 1'b0;
      open_run(sc);
    end else if (run_len >= MAX_RUN_DEF) begin
      flush_run(1'b1, 1'b0);
      split_open = 1'b1;
      open_run(sc);
    end
    if (positive) begin
      if (pos_total < count_max) pos_total++;
    end else begin
      if (neg_total < count_max) neg_total++;
    end
    run_len++;
    if (eod) begin
      flush_run(split_open, 1'b1);
      clear();
    end
    if (due_rows.size() > before_n) due_rows[due_rows.size()-1].last = 1'b1;
  endfunction

  function int pending();
    return due_rows.size();
  endfunction

  task report(string msg);
    if (error_count < 200) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  task check_row(conf_row_t got);
    conf_row_t want;
    if (due_rows.size() == 0) begin
      report($sformatf("row with none due: tp %h fp %h score %h",
                       got.tp_count, got.fp_count, got.row_score));
      return;
    end
    want = due_rows.pop_front();
    if (got.tp_count !== want.tp_count)
      report($sformatf("tp_count %h, want %h", got.tp_count, want.tp_count));
    if (got.fp_count !== want.fp_count)
      report($sformatf("fp_count %h, want %h", got.fp_count, want.fp_count));
    if (got.row_score !== want.row_score)
      report($sformatf("row_score %h, want %h", got.row_score, want.row_score));
    if (got.is_interpolated !== want.is_interpolated)
      report($sformatf("is_interpolated %b, want %b", got.is_interpolated,
                       want.is_interpolated));
    if (got.run_split !== want.run_split)
      report($sformatf("run_split %b, want %b", got.run_split, want.run_split));
    if (got.final_row !== want.final_row)
      report($sformatf("final_row %b, want %b", got.final_row, want.final_row));
    if (got.last !== want.last)
      report($sformatf("last %b, want %b", got.last, want.last));
  endtask

  task close_out();
    if (due_rows.size() != 0) report($sformatf("%0d rows never arrived", due_rows.size()));
  endtask
endclass

module tie_averaged_confusion_counts_top_test;

  localparam int CLK_PERIOD     = 20;
  localparam int ITEM_GOAL      = 330;
  localparam int DRAIN_CYCLES   = 100;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int send_idle_pct = 33;
  int sink_idle_pct = 86;
  int items_sent    = 0;

  row_ledger ledger = new();

  tacc_item_if item_ch ();
  tacc_row_if  row_ch ();

  tie_averaged_confusion_counts_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_ch),
    .row_o  (row_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Take rows at random and check each word taken.
  always @(posedge clk_i) begin
    if (row_ch.valid === 1'b1 && row_ch.ready === 1'b1)
      ledger.check_row('{row_ch.tp_count, row_ch.fp_count, row_ch.row_score,
                         row_ch.is_interpolated, row_ch.run_split, row_ch.final_row,
                         row_ch.last});
    row_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic send_item(bit positive, bit [SCORE_W-1:0] sc, bit eod);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid          <= 1'b1;
    item_ch.label_positive <= positive;
    item_ch.score          <= sc;
    item_ch.end_of_data    <= eod;
    @(posedge clk_i);
    while (item_ch.ready !== 1'b1) @(posedge clk_i);
    ledger.note_item(positive, sc, eod);
    items_sent++;
  endtask

  task automatic send_run(bit [SCORE_W-1:0] sc, int len, bit closes);
    for (int i = 0; i < len; i++)
      send_item($urandom_range(0, 1), sc, closes && (i == len - 1));
  endtask

  task automatic send_data_set(bit force_long);
    int               n_runs;
    int               len;
    bit [SCORE_W-1:0] sc;
    n_runs = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0:       sc = SCORE_MIN;
      1:       sc = '0;
      2:       sc = 32'h7fff_ffff;
      default: sc = $urandom;
    endcase
    for (int r = 0; r < n_runs; r++) begin
      // mostly short ties, now and then one around the split length
      if (force_long && r == 0) len = 2 * MAX_RUN_DEF + 1;
      else if ($urandom_range(0, 14) == 0) len = $urandom_range(MAX_RUN_DEF - 3, MAX_RUN_DEF + 7);
      else len = $urandom_range(1, 4);
      send_run(sc, len, r == n_runs - 1);
      case ($urandom_range(0, 9))
        0:          ;  // same score again: merge into the open run
        1, 2, 3, 4: sc = $urandom;
        default:    sc = sc - $urandom_range(1, 1000);
      endcase
    end
  endtask

  initial begin
    item_ch.valid          = 1'b0;
    item_ch.label_positive = 1'b0;
    item_ch.score          = '0;
    item_ch.end_of_data    = 1'b0;
    row_ch.ready           = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single item at the minimum score
    send_item(1'b1, SCORE_MIN, 1'b1);
    // tie at the maximum, a mixed tie, then a closing item
    send_item(1'b0, 32'h7fff_ffff, 1'b0);
    send_item(1'b1, 32'h7fff_ffff, 1'b0);
    send_item(1'b1, 32'h7fff_ffff, 1'b0);
    send_item(1'b0, 32'd5, 1'b0);
    send_item(1'b1, 32'd5, 1'b0);
    send_item(1'b0, 32'd5, 1'b0);
    send_item(1'b1, 32'hffff_fff9, 1'b1);
    // first score equal to the cleared run score, end inside a tie
    send_item(1'b1, 32'd0, 1'b0);
    send_item(1'b1, 32'd0, 1'b0);
    send_item(1'b0, 32'hffff_ffff, 1'b0);
    send_item(1'b0, 32'hffff_ffff, 1'b1);
    send_item(1'b0, 32'd1, 1'b1);
    send_item(1'b0, 32'd100, 1'b0);
    send_item(1'b1, 32'd100, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 86 : 0;
      sink_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 33 : 0;
      send_data_set(phase == 0);
      while (items_sent < (phase + 1) * ITEM_GOAL / 3) send_data_set(1'b0);
      // hold the sender until every row is out
      item_ch.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clk_i);
      @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    ledger.close_out();
    if (ledger.error_count == 0) begin
      $display("tie_averaged_confusion_counts_top_test: clean");
    end else begin
      $display("tie_averaged_confusion_counts_top_test: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tie_averaged_confusion_counts_top_test: errors");
    $finish;
  end

endmodule
